@@ hw/rtl/scct_pkg.sv @@
// shared constants, payload types and entry layout for the syndrome correction table
package scct_pkg;

  localparam int ENTRY_CAPACITY = 1024;
  localparam int SYNDROME_BITS  = 16;
  localparam int BUCKET_COUNT   = ENTRY_CAPACITY / 2;
  localparam int ENT_AW         = $clog2(ENTRY_CAPACITY);
  localparam int BKT_AW         = $clog2(BUCKET_COUNT);
  localparam int LINK_W         = $clog2(ENTRY_CAPACITY + 1);
  localparam int KEY_W          = SYNDROME_BITS;
  localparam int VAL_W          = 64;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [VAL_W-1:0]  val_t;

  // link code: zero is no child, otherwise entry number plus one
  localparam link_t NO_LINK = '0;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] syndrome_bits;
    logic [63:0] correction_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] lookup_value;
    logic        found;
    logic        store_full;
  } out_item_t;

  typedef struct packed {
    key_t  key;
    val_t  value;
    link_t left;
    link_t right;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hw/rtl/scct_ram.sv @@
// simple dual-port synchronous ram, one write and one registered read port
module scct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/scct_ctrl.sv @@
// sequencer: head clear sweep, tree walk over the entry store and result forming
module scct_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  scct_pkg::in_item_t         in_data,
  output logic                       res_valid,
  input  logic                       res_take,
  output scct_pkg::out_item_t        res_data,
  output logic                       head_we,
  output logic [scct_pkg::BKT_AW-1:0] head_waddr,
  output scct_pkg::link_t            head_wdata,
  output logic                       head_re,
  output logic [scct_pkg::BKT_AW-1:0] head_raddr,
  input  scct_pkg::link_t            head_rdata,
  output logic                       entry_we,
  output logic [scct_pkg::ENT_AW-1:0] entry_waddr,
  output scct_pkg::entry_t           entry_wdata,
  output logic                       entry_re,
  output logic [scct_pkg::ENT_AW-1:0] entry_raddr,
  input  scct_pkg::entry_t           entry_rdata
);
  import scct_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_HEAD, ST_ROOT, ST_WALK, ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [BKT_AW-1:0] clr_r, clr_nxt;
  logic              mode_r, mode_nxt;
  key_t              key_r, key_nxt;
  val_t              val_r, val_nxt;
  link_t             fill_r, fill_nxt;
  logic [ENT_AW-1:0] cur_r, cur_nxt;
  out_item_t         res_r, res_nxt;

  logic              full;
  logic [BKT_AW-1:0] bucket;
  link_t             slot_link;
  link_t             head_m1;
  link_t             child;
  link_t             child_m1;
  logic              go_right;
  entry_t            upd;

  assign full      = (fill_r == LINK_W'(ENTRY_CAPACITY));
  assign bucket    = key_r[BKT_AW-1:0];
  assign slot_link = fill_r + LINK_W'(1);
  assign head_m1   = head_rdata - LINK_W'(1);
  assign go_right  = (key_r > entry_rdata.key);
  assign child     = go_right ? entry_rdata.right : entry_rdata.left;
  assign child_m1  = child - LINK_W'(1);

  always_comb begin
    upd = entry_rdata;
    if (go_right) begin
      upd.right = slot_link;
    end else begin
      upd.left = slot_link;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    mode_nxt    = mode_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    fill_nxt    = fill_r;
    cur_nxt     = cur_r;
    res_nxt     = res_r;
    head_we     = 1'b0;
    head_waddr  = bucket;
    head_wdata  = NO_LINK;
    head_re     = 1'b0;
    head_raddr  = bucket;
    entry_we    = 1'b0;
    entry_waddr = fill_r[ENT_AW-1:0];
    entry_wdata = '{key: key_r, value: val_r, left: NO_LINK, right: NO_LINK};
    entry_re    = 1'b0;
    entry_raddr = child_m1[ENT_AW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        clr_nxt    = clr_r + BKT_AW'(1);
        if (clr_r == BKT_AW'(BUCKET_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_data.mode;
          key_nxt   = in_data.syndrome_bits[KEY_W-1:0];
          val_nxt   = in_data.correction_value;
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (mode_r == MODE_INSERT && full) begin
          res_nxt   = '{lookup_value: '0, found: 1'b0, store_full: 1'b1};
          state_nxt = ST_DONE;
        end else begin
          head_re   = 1'b1;
          // new entry goes to the next free slot before it is linked
          entry_we  = (mode_r == MODE_INSERT);
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (head_rdata == NO_LINK) begin
          if (mode_r == MODE_INSERT) begin
            head_we    = 1'b1;
            head_wdata = slot_link;
            fill_nxt   = slot_link;
          end
          res_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          entry_re    = 1'b1;
          entry_raddr = head_m1[ENT_AW-1:0];
          cur_nxt     = head_m1[ENT_AW-1:0];
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (mode_r == MODE_LOOKUP && entry_rdata.key == key_r) begin
          res_nxt   = '{lookup_value: entry_rdata.value, found: 1'b1, store_full: 1'b0};
          state_nxt = ST_DONE;
        end else if (child == NO_LINK) begin
          if (mode_r == MODE_INSERT) begin
            entry_we    = 1'b1;
            entry_waddr = cur_r;
            entry_wdata = upd;
            fill_nxt    = slot_link;
          end
          res_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          entry_re = 1'b1;
          cur_nxt  = child_m1[ENT_AW-1:0];
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      fill_r  <= fill_nxt;
    end
    mode_r <= mode_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    cur_r  <= cur_nxt;
    res_r  <= res_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res_data  = res_r;

endmodule

@@ hw/rtl/syndrome_correction_table.sv @@
// top level of the syndrome correction table: memories, sequencer and output register
// Key-value store mapping a syndrome (key) to a 64-bit correction word. The
// low bits of the key pick one of 512 buckets; each bucket heads a binary
// search tree of entries in a 1024-entry store, greater keys to the right,
// equal or smaller to the left. An insert (mode 0) takes the next free slot
// and links it under the tree; when all 1024 entries are used the insert is
// dropped and store_full is returned. A lookup (mode 1) returns the oldest
// entry with an equal key, or zero with found clear. Every item gives exactly
// one result. After reset the block clears the bucket heads and holds
// in_stall high meanwhile. Each item then runs through a head read, a check
// of the head that starts the root read, one registered entry store read per
// tree node visited, and a hold of the formed result until the output
// register takes it; a dropped insert skips the reads. Items are processed
// one at a time: a new item is not taken before the last one's result has
// left the sequencer for the output register. The next one is taken while a
// finished result still waits in the output register.
module syndrome_correction_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scct_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scct_pkg::out_item_t out_data
);
  import scct_pkg::*;

  // sequencer to output register
  logic              res_valid;
  logic              res_take;
  out_item_t         res_data;

  // bucket head memory
  logic              head_we;
  logic [BKT_AW-1:0] head_waddr;
  link_t             head_wdata;
  logic              head_re;
  logic [BKT_AW-1:0] head_raddr;
  link_t             head_rdata;

  // entry store: key, correction and both child links in one word
  logic              entry_we;
  logic [ENT_AW-1:0] entry_waddr;
  entry_t            entry_wdata;
  logic              entry_re;
  logic [ENT_AW-1:0] entry_raddr;
  entry_t            entry_rdata;

  // output register
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;

  scct_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_data    (res_data),
    .head_we     (head_we),
    .head_waddr  (head_waddr),
    .head_wdata  (head_wdata),
    .head_re     (head_re),
    .head_raddr  (head_raddr),
    .head_rdata  (head_rdata),
    .entry_we    (entry_we),
    .entry_waddr (entry_waddr),
    .entry_wdata (entry_wdata),
    .entry_re    (entry_re),
    .entry_raddr (entry_raddr),
    .entry_rdata (entry_rdata)
  );

  scct_ram #(
    .WIDTH (LINK_W),
    .DEPTH (BUCKET_COUNT)
  ) u_head_mem (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (head_re),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  scct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_CAPACITY)
  ) u_entry_mem (
    .clk   (clk),
    .we    (entry_we),
    .waddr (entry_waddr),
    .wdata (entry_wdata),
    .re    (entry_re),
    .raddr (entry_raddr),
    .rdata (entry_rdata)
  );

  // the output register loads when empty or when its result transfers out
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // no item is taken while the bucket heads are being cleared
  a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during head clear");

  // a result never flags both a dropped insert and a lookup hit
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.store_full))
    else $error("found and store_full both set");

  // a miss or an insert carries a zero correction
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.lookup_value == '0))
    else $error("nonzero correction without a hit");
`endif

endmodule
